// ===== sv/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// shared types and constants of the semaphore table
// ----------------------------------------------------------------------------
`default_nettype none
package cst_pkg;
   localparam int NumSemaphoresDefault = 128;
   localparam int QueueDepthDefault    = 32;
   localparam int HandleMax            = 255;

   typedef enum logic [1:0] {
      REQ_CREATE = 2'd0,
      REQ_UP     = 2'd1,
      REQ_DOWN   = 2'd2,
      REQ_DELETE = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BLOCKED    = 3'd1,
      ST_INVALID    = 3'd2,
      ST_NO_SLOT    = 3'd3,
      ST_AT_LIMIT   = 3'd4,
      ST_QUEUE_FULL = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_READ,
      FSM_QREAD,
      FSM_RESP
   } fsm_type;
endpackage
`default_nettype wire

// ===== sv/cst_slot_finder.sv =====
// ----------------------------------------------------------------------------
// cst_slot_finder
// in-use flags and lowest free slot search with a registered result
// ----------------------------------------------------------------------------
`default_nettype none
module cst_slot_finder #(
   parameter int NumSlots = 128,
   parameter int SlotBits = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                set_en,
   input  wire logic                clr_en,
   input  wire logic [SlotBits-1:0] wr_slot,
   input  wire logic [SlotBits-1:0] rd_slot,
   output logic                     rd_used,
   output logic                     free_found,
   output logic [SlotBits-1:0]      free_slot
);
   logic [NumSlots-1:0] used_ff;
   logic                found_in;
   logic [SlotBits-1:0] slot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         if (set_en) used_ff[wr_slot] <= 1'b1;
         if (clr_en) used_ff[wr_slot] <= 1'b0;
      end
   end

   assign rd_used = used_ff[rd_slot];

   // priority encode; result registered so the search sits alone in its cycle
   always_comb begin
      found_in = 1'b0;
      slot_in  = '0;
      for (int i = NumSlots - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            found_in = 1'b1;
            slot_in  = SlotBits'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      free_found <= found_in;
      free_slot  <= slot_in;
   end
endmodule
`default_nettype wire

// ===== sv/cst_entry_mem.sv =====
// ----------------------------------------------------------------------------
// cst_entry_mem
// per-semaphore record memory and wait queue pid memory
// ----------------------------------------------------------------------------
`default_nettype none
module cst_entry_mem #(
   parameter int NumSlots  = 128,
   parameter int SlotBits  = 7,
   parameter int QBits     = 5,
   parameter int EntryBits = 40
) (
   input  wire logic                      clock,
   input  wire logic                      ent_we,
   input  wire logic [SlotBits-1:0]       ent_addr,
   input  wire logic [EntryBits-1:0]      ent_wdata,
   output logic      [EntryBits-1:0]      ent_rdata,
   input  wire logic                      q_we,
   input  wire logic [SlotBits+QBits-1:0] q_addr,
   input  wire logic [15:0]               q_wdata,
   output logic      [15:0]               q_rdata
);
   logic [EntryBits-1:0] ent_mem [NumSlots];
   logic [15:0]          q_mem   [NumSlots * (2 ** QBits)];

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_addr] <= ent_wdata;
      ent_rdata <= ent_mem[ent_addr];
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_addr] <= q_wdata;
      q_rdata <= q_mem[q_addr];
   end
endmodule
`default_nettype wire

// ===== sv/counting_semaphore_table.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_table
// semaphore table with per-entry fifo wait queues
// ----------------------------------------------------------------------------
//  channel | direction | beat
//  req_    | in        | req_type, handle, pid, counting_mode, start_count
//  rsp_    | out       | status, new_handle, woken_valid, woken_pid
//
//  one request at a time: the result beat is offered after the request
//  passes the read state, and after a further queue read state for an up
//  that wakes a waiter (extra queue read). the next request is taken the
//  cycle after the result beat, so a new request waits for the last result.
//  reset clears the in-use flags and the fsm state; record memories need no clearing.
//  a held result stalls the next request until the rsp_ beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module counting_semaphore_table #(
   parameter int NUM_SEMAPHORES = cst_pkg::NumSemaphoresDefault,
   parameter int QUEUE_DEPTH    = cst_pkg::QueueDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_handle,
   input  wire logic [15:0] req_pid,
   input  wire logic        req_counting_mode,
   input  wire logic [15:0] req_start_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_new_handle,
   output logic             rsp_woken_valid,
   output logic [15:0]      rsp_woken_pid
);
   import cst_pkg::*;

   localparam int Usable    = NUM_SEMAPHORES < HandleMax ? NUM_SEMAPHORES : HandleMax;
   localparam int SlotBits  = Usable > 1 ? $clog2(Usable) : 1;
   localparam int QBits     = $clog2(QUEUE_DEPTH);
   localparam int QBitsW    = QBits > 0 ? QBits : 1;
   localparam int CntBits   = $clog2(QUEUE_DEPTH + 1);
   // entry: count, mode, head, occupancy
   localparam int EntryBits = 16 + 1 + QBitsW + CntBits;
   localparam int QAddrBits = SlotBits + QBitsW;

   fsm_type state_ff, state_in;
   logic [1:0]  op_ff;
   logic [15:0] pid_ff;
   logic        mode_ff;
   logic [15:0] init_ff;
   logic [SlotBits-1:0] slot_ff, slot_in;
   logic        bad_ff;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  nh_ff, nh_in;
   logic        wv_ff, wv_in;
   logic [15:0] wp_ff, wp_in;

   logic        rd_used, free_found, set_en, clr_en;
   logic [SlotBits-1:0] free_slot;
   logic [SlotBits-1:0] wr_slot;
   logic        ent_we, q_we;
   logic [SlotBits-1:0]  ent_addr;
   logic [EntryBits-1:0] ent_wdata, ent_rdata;
   logic [QAddrBits-1:0] q_addr;
   logic [15:0]          q_rdata;

   logic [15:0]        e_cnt;
   logic               e_mode;
   logic [QBitsW-1:0]  e_head, tail;
   logic [CntBits-1:0] e_occ;
   logic               hvalid;

   assign {e_cnt, e_mode, e_head, e_occ} = ent_rdata;
   assign tail = QBitsW'(e_head + e_occ);

   assign hvalid  = req_handle != 8'd0 && {24'd0, req_handle} <= 32'(Usable);
   assign slot_in = SlotBits'(req_handle - 8'd1);

   // create marks the free slot, delete clears the addressed one
   assign wr_slot = op_ff == REQ_CREATE ? free_slot : slot_ff;

   cst_slot_finder #(.NumSlots(Usable), .SlotBits(SlotBits)) u_finder (
      .clock, .reset, .set_en, .clr_en,
      .wr_slot(wr_slot), .rd_slot(slot_ff), .rd_used,
      .free_found, .free_slot
   );

   cst_entry_mem #(.NumSlots(Usable), .SlotBits(SlotBits), .QBits(QBitsW),
                   .EntryBits(EntryBits)) u_mem (
      .clock, .ent_we, .ent_addr, .ent_wdata, .ent_rdata,
      .q_we, .q_addr, .q_wdata(pid_ff), .q_rdata
   );

   assign req_ready       = state_ff == FSM_IDLE;
   assign rsp_valid       = state_ff == FSM_RESP;
   assign rsp_status      = status_ff;
   assign rsp_new_handle  = nh_ff;
   assign rsp_woken_valid = wv_ff;
   assign rsp_woken_pid   = wp_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FSM_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= req_type;
         pid_ff  <= req_pid;
         mode_ff <= req_counting_mode;
         init_ff <= req_start_count;
         slot_ff <= slot_in;
         bad_ff  <= !hvalid;
      end else if (state_ff == FSM_READ && op_ff == REQ_CREATE) begin
         slot_ff <= free_slot;
      end
      status_ff <= status_in;
      nh_ff     <= nh_in;
      wv_ff     <= wv_in;
      wp_ff     <= wp_in;
   end

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      nh_in     = nh_ff;
      wv_in     = wv_ff;
      wp_in     = wp_ff;
      set_en    = 1'b0;
      clr_en    = 1'b0;
      ent_we    = 1'b0;
      ent_addr  = slot_ff;
      ent_wdata = ent_rdata;
      q_we      = 1'b0;
      q_addr    = {slot_ff, e_head};
      unique case (state_ff)
         FSM_IDLE: begin
            ent_addr = slot_in;
            if (req_valid) state_in = FSM_READ;
         end
         FSM_READ: begin
            status_in = ST_OK;
            nh_in     = '0;
            wv_in     = 1'b0;
            wp_in     = '0;
            state_in  = FSM_RESP;
            if (op_ff == REQ_CREATE) begin
               if (!free_found) begin
                  status_in = ST_NO_SLOT;
               end else begin
                  set_en    = 1'b1;
                  ent_we    = 1'b1;
                  ent_addr  = free_slot;
                  ent_wdata = {init_ff, mode_ff, QBitsW'(0), CntBits'(0)};
                  nh_in     = 8'(free_slot) + 8'd1;
               end
            end else if (bad_ff || !rd_used) begin
               status_in = ST_INVALID;
            end else begin
               unique case (op_ff)
                  REQ_UP: begin
                     if (e_cnt == 16'd0 && e_occ != '0) begin
                        ent_we    = 1'b1;
                        ent_wdata = {e_cnt, e_mode, QBitsW'(e_head + 1'b1),
                                     CntBits'(e_occ - 1'b1)};
                        state_in  = FSM_QREAD;
                     end else if ((!e_mode && e_cnt != 16'd0) || e_cnt == 16'hFFFF) begin
                        status_in = ST_AT_LIMIT;
                     end else begin
                        ent_we    = 1'b1;
                        ent_wdata = {16'(e_cnt + 16'd1), e_mode, e_head, e_occ};
                     end
                  end
                  REQ_DOWN: begin
                     if (e_cnt != 16'd0) begin
                        ent_we    = 1'b1;
                        ent_wdata = {16'(e_cnt - 16'd1), e_mode, e_head, e_occ};
                     end else if (32'(e_occ) >= 32'(QUEUE_DEPTH)) begin
                        status_in = ST_QUEUE_FULL;
                     end else begin
                        ent_we    = 1'b1;
                        ent_wdata = {e_cnt, e_mode, e_head, CntBits'(e_occ + 1'b1)};
                        q_we      = 1'b1;
                        q_addr    = {slot_ff, tail};
                        status_in = ST_BLOCKED;
                     end
                  end
                  default: begin
                     clr_en = 1'b1;
                  end
               endcase
            end
         end
         FSM_QREAD: begin
            wv_in    = 1'b1;
            wp_in    = q_rdata;
            state_in = FSM_RESP;
         end
         FSM_RESP: begin
            if (rsp_ready) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end
endmodule
`default_nettype wire
